// File: rtl/i2c_master_transfer_sequencer_unit_assert.svh
`ifndef I2C_MASTER_TRANSFER_SEQUENCER_UNIT_ASSERT_SVH
`define I2C_MASTER_TRANSFER_SEQUENCER_UNIT_ASSERT_SVH

// clocked check, muted while reset is high
`define IMTS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked check that also holds through reset
`define IMTS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/imts_pkg.sv
package imts_pkg;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_EVENT = 2'd1,
    CMD_ERROR = 2'd2
  } cmd_t;

  localparam logic [23:0] EV_MODE_SELECT   = 24'h030001;
  localparam logic [23:0] EV_TX_SELECTED   = 24'h070082;
  localparam logic [23:0] EV_RX_SELECTED   = 24'h030002;
  localparam logic [23:0] EV_BYTE_RECEIVED = 24'h030040;
  localparam logic [23:0] EV_BYTE_SENDING  = 24'h070080;
  localparam logic [23:0] EV_BYTE_SENT     = 24'h070084;
  localparam logic [23:0] SR1_NACK         = 24'h000400;
  localparam logic [7:0]  DIR_READ         = 8'h01;
  localparam logic [1:0]  ADDR_BYTES_MAX   = 2'd2;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [23:0] status_flags;
    logic [7:0]  rx_data;
    logic [7:0]  tx_data;
    logic [7:0]  device_address;
    logic [7:0]  reg_addr_first;
    logic [7:0]  reg_addr_second;
    logic [1:0]  reg_addr_count;
    logic [15:0] tx_count;
    logic [15:0] rx_count;
  } item_t;

  typedef struct packed {
    logic       data_write_valid;
    logic [7:0] data_write_byte;
    logic       tx_byte_taken;
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic       gen_start;
    logic       gen_stop;
    logic       ack_enabled;
    logic       buffer_irq_enabled;
    logic       event_irq_enabled;
    logic       clear_status;
    logic       busy_res;
  } result_t;

endpackage

// File: rtl/i2c_master_transfer_sequencer_unit.sv
// channel   direction  signals                               beat
// item      in         item_valid / item_ready / item        command + status word
// result    out        result_valid / result_ready / result  one answer per item
//
// one item per cycle sustained while result_ready keeps up; result becomes valid once the item
// has passed the input register, then the sequencer state update into the result register
// rst is synchronous: sequencer state returns to idle with ack enabled
// a stalled result holds the input register; item_ready drops only while both are full
module i2c_master_transfer_sequencer_unit #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  imts_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_ready,
  output imts_pkg::result_t result
);
  import imts_pkg::*;

  logic    held_valid;
  item_t   held;
  logic    advance;
  result_t core_res;

  assign advance    = held_valid && (!result_valid || result_ready);
  assign item_ready = !held_valid || advance;

  imts_core #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_core (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (held),
    .res     (core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (item_ready) begin
        held_valid <= item_valid;
      end
      if (advance) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      held <= item;
    end
    if (advance) begin
      result <= core_res;
    end
  end

endmodule

// File: rtl/imts_core.sv
module imts_core #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             advance,
  input  imts_pkg::item_t   item,
  output imts_pkg::result_t res
);
  import imts_pkg::*;

  logic [7:0]             slave_addr, slave_addr_next;
  logic [7:0]             addr_bytes [2];
  logic [7:0]             addr_bytes_next [2];
  logic [1:0]             addr_left, addr_left_next;
  logic [COUNT_WIDTH-1:0] tx_left, tx_left_next;
  logic [COUNT_WIDTH-1:0] rx_left, rx_left_next;
  logic [COUNT_WIDTH-1:0] rx_dec;
  logic                   busy_flag, busy_flag_next;
  logic                   ack_flag, ack_flag_next;
  logic                   buf_irq_flag, buf_irq_flag_next;
  logic                   evt_irq_flag, evt_irq_flag_next;
  logic                   is_tx_selected;

  assign rx_dec = rx_left - COUNT_WIDTH'(1);
  assign is_tx_selected = (item.status_flags == EV_TX_SELECTED);

  always_comb begin
    res                = '0;
    slave_addr_next    = slave_addr;
    addr_bytes_next[0] = addr_bytes[0];
    addr_bytes_next[1] = addr_bytes[1];
    addr_left_next     = addr_left;
    tx_left_next       = tx_left;
    rx_left_next       = rx_left;
    busy_flag_next     = busy_flag;
    ack_flag_next      = ack_flag;
    buf_irq_flag_next  = buf_irq_flag;
    evt_irq_flag_next  = evt_irq_flag;

    case (item.cmd)
      CMD_START: begin
        slave_addr_next    = item.device_address;
        addr_bytes_next[0] = item.reg_addr_first;
        addr_bytes_next[1] = item.reg_addr_second;
        addr_left_next     = (item.reg_addr_count > ADDR_BYTES_MAX) ? ADDR_BYTES_MAX
                                                                    : item.reg_addr_count;
        tx_left_next       = COUNT_WIDTH'(item.tx_count);
        rx_left_next       = COUNT_WIDTH'(item.rx_count);
        buf_irq_flag_next  = 1'b0;
        evt_irq_flag_next  = 1'b1;
        ack_flag_next      = 1'b1;
        busy_flag_next     = 1'b1;
        res.gen_start      = 1'b1;
      end
      CMD_EVENT: begin
        case (item.status_flags)
          EV_MODE_SELECT: begin
            res.data_write_valid = 1'b1;
            if (tx_left != '0 || addr_left != '0) begin
              res.data_write_byte = slave_addr;
            end else begin
              res.data_write_byte = slave_addr | DIR_READ;
            end
          end
          EV_TX_SELECTED, EV_BYTE_SENDING: begin
            if (is_tx_selected) begin
              buf_irq_flag_next = 1'b1;
            end
            if (addr_left != '0) begin
              res.data_write_valid = 1'b1;
              res.data_write_byte  = addr_bytes[~addr_left[1]];
              addr_left_next       = addr_left - 2'd1;
            end else if (tx_left != '0) begin
              res.data_write_valid = 1'b1;
              res.data_write_byte  = item.tx_data;
              res.tx_byte_taken    = 1'b1;
              tx_left_next         = tx_left - COUNT_WIDTH'(1);
            end else begin
              buf_irq_flag_next = 1'b0;
            end
          end
          EV_BYTE_SENT: begin
            if (rx_left != '0) begin
              res.gen_start = 1'b1;
            end else begin
              res.gen_stop      = 1'b1;
              evt_irq_flag_next = 1'b0;
              busy_flag_next    = 1'b0;
            end
          end
          EV_RX_SELECTED: begin
            if (rx_left == COUNT_WIDTH'(1)) begin
              ack_flag_next = 1'b0;
              res.gen_stop  = 1'b1;
            end
            buf_irq_flag_next = 1'b1;
          end
          EV_BYTE_RECEIVED: begin
            if (rx_left != '0) begin
              res.rx_valid = 1'b1;
              res.rx_byte  = item.rx_data;
              rx_left_next = rx_dec;
              if (rx_dec == COUNT_WIDTH'(1)) begin
                ack_flag_next = 1'b0;
                res.gen_stop  = 1'b1;
              end else if (rx_dec == '0) begin
                evt_irq_flag_next = 1'b0;
                busy_flag_next    = 1'b0;
              end
            end else begin
              evt_irq_flag_next = 1'b0;
              busy_flag_next    = 1'b0;
            end
          end
          default: begin
            res.clear_status = 1'b1;
          end
        endcase
      end
      CMD_ERROR: begin
        if ((item.status_flags & SR1_NACK) != '0) begin
          res.gen_stop = 1'b1;
        end
        res.clear_status = 1'b1;
        busy_flag_next   = 1'b0;
      end
      default: begin
      end
    endcase

    res.ack_enabled        = ack_flag_next;
    res.buffer_irq_enabled = buf_irq_flag_next;
    res.event_irq_enabled  = evt_irq_flag_next;
    res.busy_res           = busy_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slave_addr    <= '0;
      addr_bytes[0] <= '0;
      addr_bytes[1] <= '0;
      addr_left     <= '0;
      tx_left       <= '0;
      rx_left       <= '0;
      busy_flag     <= 1'b0;
      ack_flag      <= 1'b1;
      buf_irq_flag  <= 1'b0;
      evt_irq_flag  <= 1'b0;
    end else if (advance) begin
      slave_addr    <= slave_addr_next;
      addr_bytes[0] <= addr_bytes_next[0];
      addr_bytes[1] <= addr_bytes_next[1];
      addr_left     <= addr_left_next;
      tx_left       <= tx_left_next;
      rx_left       <= rx_left_next;
      busy_flag     <= busy_flag_next;
      ack_flag      <= ack_flag_next;
      buf_irq_flag  <= buf_irq_flag_next;
      evt_irq_flag  <= evt_irq_flag_next;
    end
  end

endmodule

// File: rtl/imts_checker.sv
`include "i2c_master_transfer_sequencer_unit_assert.svh"

module imts_checker (
  input logic              clk,
  input logic              rst,
  input logic              item_valid,
  input logic              item_ready,
  input logic              result_valid,
  input logic              result_ready,
  input imts_pkg::result_t result
);
  import imts_pkg::*;

  `IMTS_ASSERT(a_result_hold,
    result_valid && !result_ready |=> result_valid && $stable(result),
    "result beat changed while stalled")
  `IMTS_ASSERT(a_wr_byte_zero,
    result_valid && !result.data_write_valid |-> result.data_write_byte == 8'd0,
    "write byte set without write")
  `IMTS_ASSERT(a_rx_byte_zero,
    result_valid && !result.rx_valid |-> result.rx_byte == 8'd0,
    "rx byte set without rx valid")
  `IMTS_ASSERT(a_tx_needs_wr,
    result_valid && result.tx_byte_taken |-> result.data_write_valid,
    "tx byte taken without data write")
  `IMTS_ASSERT_ALWAYS(a_reset_empty, rst |=> !result_valid, "result valid straight after reset")

endmodule

bind i2c_master_transfer_sequencer_unit imts_checker u_imts_checker (.*);
